>>> sv/ymf_pkg.sv
`default_nettype none
package ymf_pkg;

  localparam int unsigned LongLen  = 1024;
  localparam int unsigned ShortLen = 128;
  localparam int unsigned BufAw    = 10;

  localparam logic [7:0] ChSoh = 8'h01;
  localparam logic [7:0] ChStx = 8'h02;
  localparam logic [7:0] ChEot = 8'h04;
  localparam logic [7:0] ChAck = 8'h06;
  localparam logic [7:0] ChNak = 8'h15;
  localparam logic [7:0] ChC   = 8'h43;
  localparam logic [15:0] CrcPoly = 16'h1021;

  typedef enum logic [1:0] {
    OP_RX   = 2'd0,
    OP_TICK = 2'd1,
    OP_READ = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    SS_WAIT_HDR = 3'd0,
    SS_SEND_ACK = 3'd1,
    SS_SEND_C   = 3'd2,
    SS_DATA     = 3'd3,
    SS_END_C    = 3'd4,
    SS_WAIT_END = 3'd5,
    SS_DONE     = 3'd6
  } session_e;

  typedef enum logic [1:0] {
    FR_HUNT = 2'd0,
    FR_SEQ  = 2'd1,
    FR_INV  = 2'd2,
    FR_DATA = 2'd3
  } frame_e;

  typedef enum logic [1:0] {
    HF_NAME = 2'd0,
    HF_SIZE = 2'd1,
    HF_REST = 2'd2
  } hfield_e;

  localparam logic [2:0] KindNone  = 3'd0;
  localparam logic [2:0] KindStart = 3'd1;
  localparam logic [2:0] KindD128  = 3'd2;
  localparam logic [2:0] KindD1k   = 3'd3;
  localparam logic [2:0] KindEot   = 3'd4;
  localparam logic [2:0] KindEnd   = 3'd5;

  localparam logic [2:0] ErrOk    = 3'd0;
  localparam logic [2:0] ErrSeq   = 3'd1;
  localparam logic [2:0] ErrCrc   = 3'd2;
  localparam logic [2:0] ErrState = 3'd3;
  localparam logic [2:0] ErrName  = 3'd4;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
    logic [9:0] read_index;
  } in_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        frame_done;
    logic [2:0]  frame_kind;
    logic [2:0]  error_code;
    logic [2:0]  session_state;
    logic [31:0] file_size;
    logic [31:0] bytes_received;
    logic [7:0]  payload_byte;
  } out_t;

  typedef struct packed {
    logic             we;
    logic [BufAw-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [BufAw-1:0] raddr;
  } buf_req_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> sv/ymf_buffer.sv
`default_nettype none
module ymf_buffer import ymf_pkg::*; (
  input  wire logic     clk_i,
  input  wire buf_req_t req_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [2**BufAw];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_o <= mem[req_i.raddr];
    end
  end

endmodule
`default_nettype wire

>>> sv/ymodem_frame_receiver.sv
`default_nettype none
// YMODEM receiver with CRC-16 frame checking.
// Input channel (in_valid_i/in_ready_o, in_i): one operation per transfer:
//   a received link byte, a time tick, a payload buffer read, or a no-op.
// Output channel (out_valid_o/out_ready_i, out_o): exactly one result per
//   input transfer, in order: reply byte, frame status, session phase,
//   parsed file size, byte total and the read payload byte.
// The result is registered and presented in the cycle after its input transfer.
// Throughput: one transfer per cycle; the single result register is the
//   only buffering, so a new input is taken while the result is taken or
//   the result slot is empty.
// When the consumer stalls (out_ready_i low), the result holds and
//   in_ready_o drops until it is taken.
// Configuration: cfg_we_i writes cfg_wdata_i as the tick count before
//   each timed C or ACK. Write only while idle.
// Reset (rst_ni low, asynchronous): session waits for the start header,
//   framer hunts, counters clear, tick count returns to 10. The payload
//   buffer is not cleared; unwritten entries read back undefined.
module ymodem_frame_receiver import ymf_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire in_t        in_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output out_t            out_o
);

  logic [7:0]  wait_ticks_q;
  session_e    sess_q, sess_d;
  logic [7:0]  wait_cnt_q, wait_cnt_d;
  frame_e      fr_q, fr_d;
  logic [10:0] bcnt_q, bcnt_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  seq_q, seq_d;
  logic [7:0]  last_seq_q, last_seq_d;
  logic [1:0]  eot_q, eot_d;
  logic        long_q, long_d;
  hfield_e     hf_q, hf_d;
  logic        nz_q, nz_d;
  logic [31:0] size_q, size_d;
  logic [31:0] total_q, total_d;
  out_t        res_q, res_d;
  logic        out_valid_q;
  logic        rd_q;
  logic [7:0]  rdata;
  buf_req_t    breq;
  logic        acc;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    logic        rx_ph, hdr_pat, valid, is_hdr;
    logic [10:0] len, bn;
    logic [15:0] cn;
    logic [35:0] mul;
    logic [7:0]  b;
    b = in_i.rx_byte;
    sess_d = sess_q; wait_cnt_d = wait_cnt_q; fr_d = fr_q; bcnt_d = bcnt_q;
    crc_d = crc_q; seq_d = seq_q; last_seq_d = last_seq_q; eot_d = eot_q;
    long_d = long_q; hf_d = hf_q; nz_d = nz_q; size_d = size_q; total_d = total_q;
    res_d = '0;
    breq.we = 1'b0;
    breq.waddr = bcnt_q[BufAw-1:0];
    breq.wdata = b;
    breq.re = acc && (in_i.operation == OP_READ);
    breq.raddr = in_i.read_index;
    rx_ph = (sess_q == SS_WAIT_HDR) || (sess_q == SS_DATA) || (sess_q == SS_WAIT_END);
    len = long_q ? 11'(LongLen) : 11'(ShortLen);
    is_hdr = sess_q != SS_DATA;
    hdr_pat = !long_q && (seq_q == 8'h00) && (b == 8'hFF);
    valid = (seq_q == last_seq_q + 8'd1) && (seq_q + b == 8'hFF);
    cn = crc_byte(crc_q, b);
    bn = bcnt_q + 11'd1;
    mul = ({4'd0, size_q} << 3) + ({4'd0, size_q} << 1) + 36'(b - 8'h30);
    unique case (op_e'(in_i.operation))
      OP_TICK: begin
        if (sess_q == SS_WAIT_HDR || sess_q == SS_SEND_ACK || sess_q == SS_SEND_C ||
            sess_q == SS_END_C) begin
          if (wait_cnt_q >= wait_ticks_q) begin
            wait_cnt_d = '0;
            res_d.tx_valid = 1'b1;
            res_d.tx_byte = (sess_q == SS_SEND_ACK) ? ChAck : ChC;
            unique case (sess_q)
              SS_SEND_ACK: sess_d = SS_SEND_C;
              SS_SEND_C:   sess_d = SS_DATA;
              SS_END_C:    sess_d = SS_WAIT_END;
              default:     sess_d = sess_q;
            endcase
          end else begin
            wait_cnt_d = wait_cnt_q + 8'd1;
          end
        end
      end
      OP_RX: begin
        if (!rx_ph) begin
          fr_d = FR_HUNT;
        end else begin
          unique case (fr_q)
            FR_HUNT: begin
              if (b == ChSoh || b == ChStx) begin
                long_d = (b == ChStx);
                fr_d = FR_SEQ;
              end else if (b == ChEot) begin
                res_d.frame_done = 1'b1;
                res_d.frame_kind = KindEot;
                if (sess_q == SS_DATA) begin
                  res_d.tx_valid = 1'b1;
                  if (eot_q + 2'd1 >= 2'd2) begin
                    res_d.tx_byte = ChAck;
                    eot_d = '0;
                    sess_d = SS_END_C;
                    wait_cnt_d = '0;
                  end else begin
                    res_d.tx_byte = ChNak;
                    eot_d = eot_q + 2'd1;
                  end
                end else begin
                  res_d.error_code = ErrState;
                end
              end
            end
            FR_SEQ: begin
              seq_d = b;
              fr_d = FR_INV;
            end
            FR_INV: begin
              if (sess_q == SS_DATA && valid) begin
                fr_d = FR_DATA;
              end else if (hdr_pat && sess_q != SS_DATA) begin
                fr_d = FR_DATA;
                hf_d = HF_NAME;
                nz_d = 1'b0;
                if (sess_q == SS_WAIT_HDR) size_d = '0;
              end else begin
                res_d.frame_done = 1'b1;
                res_d.error_code = (hdr_pat || valid) ? ErrState : ErrSeq;
                fr_d = FR_HUNT;
              end
              bcnt_d = '0;
              crc_d = '0;
            end
            FR_DATA: begin
              crc_d = cn;
              if (bcnt_q < len) begin
                breq.we = acc;
                if (is_hdr) begin
                  if (b != 8'h00) nz_d = 1'b1;
                  if (hf_q == HF_NAME) begin
                    if (b == 8'h00) hf_d = HF_SIZE;
                  end else if (hf_q == HF_SIZE) begin
                    if (b >= 8'h30 && b <= 8'h39) begin
                      size_d = (mul[35:32] != 4'd0) ? 32'hFFFF_FFFF : mul[31:0];
                    end else begin
                      hf_d = HF_REST;
                    end
                  end
                end
              end
              bcnt_d = bn;
              if (bn >= len + 11'd2) begin
                fr_d = FR_HUNT;
                res_d.frame_done = 1'b1;
                if (!is_hdr) begin
                  res_d.frame_kind = long_q ? KindD1k : KindD128;
                  if (cn != 16'h0000) begin
                    res_d.error_code = ErrCrc;
                  end else begin
                    last_seq_d = seq_q;
                    total_d = ({1'b0, total_q} + {22'd0, len} > 33'h0_FFFF_FFFF) ?
                              32'hFFFF_FFFF : total_q + {21'd0, len};
                    eot_d = '0;
                    res_d.tx_valid = 1'b1;
                    res_d.tx_byte = ChAck;
                  end
                end else if (sess_q == SS_WAIT_HDR) begin
                  res_d.frame_kind = KindStart;
                  if (cn != 16'h0000) begin
                    res_d.error_code = ErrCrc;
                  end else if (hf_d == HF_NAME) begin
                    res_d.error_code = ErrName;
                  end else begin
                    sess_d = SS_SEND_ACK;
                    wait_cnt_d = '0;
                  end
                end else begin
                  res_d.frame_kind = KindEnd;
                  if (cn != 16'h0000) begin
                    res_d.error_code = ErrCrc;
                  end else if (nz_d) begin
                    res_d.error_code = ErrState;
                  end else begin
                    res_d.tx_valid = 1'b1;
                    res_d.tx_byte = ChAck;
                    sess_d = SS_DONE;
                  end
                end
              end
            end
            default: fr_d = FR_HUNT;
          endcase
        end
      end
      default: ;
    endcase
    res_d.session_state = sess_d;
    res_d.file_size = size_d;
    res_d.bytes_received = total_d;
  end

  ymf_buffer u_buffer (
    .clk_i   (clk_i),
    .req_i   (breq),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_ticks_q <= 8'd10;
      sess_q <= SS_WAIT_HDR;
      wait_cnt_q <= '0;
      fr_q <= FR_HUNT;
      bcnt_q <= '0;
      crc_q <= '0;
      seq_q <= '0;
      last_seq_q <= '0;
      eot_q <= '0;
      long_q <= 1'b0;
      hf_q <= HF_NAME;
      nz_q <= 1'b0;
      size_q <= '0;
      total_q <= '0;
      out_valid_q <= 1'b0;
      rd_q <= 1'b0;
    end else begin
      if (cfg_we_i) wait_ticks_q <= cfg_wdata_i;
      if (acc) begin
        sess_q <= sess_d;
        wait_cnt_q <= wait_cnt_d;
        fr_q <= fr_d;
        bcnt_q <= bcnt_d;
        crc_q <= crc_d;
        seq_q <= seq_d;
        last_seq_q <= last_seq_d;
        eot_q <= eot_d;
        long_q <= long_d;
        hf_q <= hf_d;
        nz_q <= nz_d;
        size_q <= size_d;
        total_q <= total_d;
        rd_q <= (in_i.operation == OP_READ);
      end
      if (acc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) res_q <= res_d;
  end

  always_comb begin
    out_o = res_q;
    out_o.payload_byte = rd_q ? rdata : 8'h00;
  end

  assign out_valid_o = out_valid_q;

  a_err_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.error_code != ErrOk) |-> out_o.frame_done)
    else $error("error code without frame end");

  a_tx_err_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.tx_valid |-> (out_o.error_code == ErrOk))
    else $error("reply sent on a rejected frame");

  a_done_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sess_q == SS_DONE) |=> (sess_q == SS_DONE))
    else $error("completed session left");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(res_q))
    else $error("stalled result changed");

endmodule
`default_nettype wire
